FILE: rtl/rfp_pkg.sv
// rfp_pkg: shared constants, types and helpers of the remote frame parser
// frame header bytes, length limit, latch window and the result word type
// no dependencies
`timescale 1ns / 1ps

package rfp_pkg;

	// frame layout
	localparam int LENGTH_LIMIT = 40;
	localparam int POS_W        = 6;
	localparam int LATCH_DEPTH  = 6;
	localparam int SLOT_W       = 3;

	localparam logic [POS_W-1:0] POS_LENGTH  = 6'd4;
	localparam logic [POS_W-1:0] FIRST_LATCH = 6'd5;
	localparam logic [POS_W-1:0] LAST_LATCH  = 6'd10;

	localparam logic [7:0] HDR0 = 8'hAA;
	localparam logic [7:0] HDR1 = 8'h29;
	localparam logic [7:0] HDR2 = 8'h05;
	localparam logic [7:0] HDR3 = 8'h42;

	// one decoded frame
	typedef struct packed {
		logic [15:0] forward_speed;
		logic [15:0] turn_pulse;
		logic [15:0] mode_pulse;
	} rfp_result_t;

	// expected header byte at positions 0..3
	function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = HDR0;
			2'd1:    b = HDR1;
			2'd2:    b = HDR2;
			default: b = HDR3;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/rfp_out_buf.sv
// rfp_out_buf: result register with one skid entry behind it
// keeps the parser taking words while a finished result waits downstream
// depends on rfp_pkg
`timescale 1ns / 1ps

module rfp_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rfp_pkg::rfp_result_t push_data,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output rfp_pkg::rfp_result_t out_data
);
	import rfp_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	rfp_result_t out_data_q;
	rfp_result_t skid_data_q;
	logic        out_free;

	// output slot can be loaded when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/remote_frame_parser.sv
// remote_frame_parser: byte-serial deframer for header AA 29 05 42 frames
// a frame-end word's result is registered into the result register or the skid entry
// throughput: one word per cycle unless in_stall; frame state updates in one compare step
// a skid entry behind the result register keeps words flowing while a result waits
// reset (arst_n low, asynchronous): hunting at position 0, length and latched bytes zero
`timescale 1ns / 1ps

module remote_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] forward_speed,
	output logic [15:0] turn_pulse,
	output logic [15:0] mode_pulse
);
	import rfp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] len_q;
	logic [7:0]       latch_q [LATCH_DEPTH];

	logic [POS_W-1:0] pos_d;
	logic [POS_W-1:0] len_d;
	logic [7:0]       latch_d [LATCH_DEPTH];
	logic [POS_W-1:0] slot_off;
	logic [SLOT_W-1:0] slot;
	logic             in_window;
	logic [POS_W:0]   end_pos;
	logic             accept;
	logic             emit;
	logic             buf_full;
	rfp_result_t      res;
	rfp_result_t      out_data;

	assign accept = in_valid && !in_stall;
	assign in_stall = buf_full;

	// latch window update, the current word lands before the words are formed
	assign slot_off  = pos_q - FIRST_LATCH;
	assign slot      = slot_off[SLOT_W-1:0];
	assign in_window = (pos_q >= FIRST_LATCH) && (pos_q <= LAST_LATCH);

	always_comb begin
		for (int i = 0; i < LATCH_DEPTH; i++) begin
			latch_d[i] = latch_q[i];
		end
		if (in_window) begin
			latch_d[slot] = rx_byte;
		end
	end

	// frame position sequencing
	assign end_pos = {1'b0, len_q} + {1'b0, FIRST_LATCH};

	always_comb begin
		pos_d = pos_q;
		len_d = len_q;
		emit  = 1'b0;
		if (pos_q < POS_LENGTH) begin
			if (rx_byte == hdr_byte(pos_q[1:0])) begin
				pos_d = pos_q + 6'd1;
			end else begin
				pos_d = '0;
			end
		end else if (pos_q == POS_LENGTH) begin
			len_d = rx_byte[POS_W-1:0];
			if (rx_byte < 8'(LENGTH_LIMIT)) begin
				pos_d = FIRST_LATCH;
			end else begin
				pos_d = '0;
			end
		end else if ({1'b0, pos_q} == end_pos) begin
			emit  = 1'b1;
			pos_d = '0;
		end else begin
			pos_d = pos_q + 6'd1;
		end
	end

	// big-endian words from the updated latch window
	assign res.forward_speed = {latch_d[0], latch_d[1]};
	assign res.turn_pulse    = {latch_d[2], latch_d[3]};
	assign res.mode_pulse    = {latch_d[4], latch_d[5]};

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			for (int i = 0; i < LATCH_DEPTH; i++) begin
				latch_q[i] <= '0;
			end
		end else if (accept) begin
			pos_q <= pos_d;
			len_q <= len_d;
			for (int i = 0; i < LATCH_DEPTH; i++) begin
				latch_q[i] <= latch_d[i];
			end
		end
	end

	// result register and skid
	rfp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && emit),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign forward_speed = out_data.forward_speed;
	assign turn_pulse    = out_data.turn_pulse;
	assign mode_pulse    = out_data.mode_pulse;

endmodule

FILE: rtl/rfp_checker.sv
// rfp_checker: port-level checks on the remote frame parser
// watches handshake and result ports only; bound to remote_frame_parser
// depends on nothing beyond the top-level port list
`timescale 1ns / 1ps

module rfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] forward_speed,
	input logic [15:0] turn_pulse,
	input logic [15:0] mode_pulse
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(forward_speed) && $stable(turn_pulse)
			&& $stable(mode_pulse))
		else $error("result changed while stalled");

	// input only backs up when a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

	// backpressure starts only after a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
		else $error("input stall without downstream stall");

	// stall clears once downstream takes the result
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("input stall held after result taken");

endmodule

bind remote_frame_parser rfp_checker u_rfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.forward_speed (forward_speed),
	.turn_pulse    (turn_pulse),
	.mode_pulse    (mode_pulse)
);
